// File: hw/rtl/pe_pkg.sv
`timescale 1ns / 1ps

package pe_pkg;

  // One index field in the packed result, and the number of such fields.
  localparam int IDX_W      = 3;
  localparam int PACK_SLOTS = 8;
  localparam int PERM_W     = IDX_W * PACK_SLOTS;
  localparam int SEQ_W      = 16;

  // Configuration port.
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;
  localparam int ITEM_COUNT_W = 4;

  localparam logic [ITEM_COUNT_W-1:0] ITEM_COUNT_RESET = 4'd8;

  // Register index, taken from the word-address bit of paddr.
  localparam logic REG_ITEM_COUNT = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init;    // clear choices, count = 1, begin the index sweep
    logic adv;     // count + 1, start unwinding from the leaf
    logic sweep;   // write identity value into the remaining-index store
    logic rd;      // read the two remaining-index entries of this level
    logic take;    // commit the choice of this level, go one level down
    logic unwind;  // put back the chosen index of the level above
    logic load;    // move the finished ordering into the output register
  } pe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic started;
    logic final_now;
    logic sweep_last;
    logic take_last;
    logic unwind_more;
    logic out_free;
  } pe_sts_t;

endpackage

// File: hw/rtl/pe_ifs.sv
`timescale 1ns / 1ps

interface pe_req_if ();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface pe_res_if import pe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PERM_W-1:0] permutation;
  logic [SEQ_W-1:0]  sequence_number;
  logic              final_res;

  modport source (output valid, output permutation, output sequence_number,
                  output final_res, input ready);
  modport sink (input valid, input permutation, input sequence_number,
                input final_res, output ready);
endinterface

// File: hw/rtl/pe_dpath.sv
`timescale 1ns / 1ps

module pe_dpath import pe_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [ITEM_COUNT_W-1:0] item_count_i,
  input  logic                    cfg_clr_i,
  input  pe_cmd_t                 cmd_i,
  output pe_sts_t                 sts_o,
  pe_res_if.source                out_ch
);

  localparam int LW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = LW + 1;

  logic [LW-1:0]    lvl_r;
  logic [SEQ_W-1:0] cnt_r;
  logic             started_r;
  logic             ov_r;
  logic [IDX_W-1:0] choice_r [DEPTH];
  logic [IDX_W-1:0] chosen_r [DEPTH];
  logic [IDX_W-1:0] rem_mem [DEPTH];
  logic [IDX_W-1:0] rd_a_r;
  logic [IDX_W-1:0] rd_b_r;
  logic [PERM_W-1:0] perm_r;
  logic [SEQ_W-1:0]  seq_r;
  logic              fin_r;

  logic [ITEM_COUNT_W:0] ic_ext;
  logic [LW-1:0]    n_eff;
  logic [LW-1:0]    n_m1;
  logic [LW-1:0]    d;
  logic [LW-1:0]    tail;
  logic [AW-1:0]    lvl_a;
  logic [AW-1:0]    d_a;
  logic [AW-1:0]    tail_a;
  logic [IDX_W-1:0] k_cur;
  logic [IDX_W-1:0] k_d;
  logic [CW-1:0]    kp1;
  logic [CW-1:0]    left;
  logic             more;
  logic             fin;
  logic [PERM_W-1:0] pack;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [IDX_W-1:0] wdata;

  // Clamp the item count to 1..DEPTH.
  always_comb begin
    ic_ext = {1'b0, item_count_i};
    if (ic_ext == '0) begin
      n_eff = LW'(1);
    end else if (ic_ext > (ITEM_COUNT_W + 1)'(DEPTH)) begin
      n_eff = LW'(DEPTH);
    end else begin
      n_eff = LW'(ic_ext);
    end
  end

  assign n_m1   = n_eff - LW'(1);
  assign d      = lvl_r - LW'(1);
  assign tail   = n_eff - lvl_r - LW'(1);
  assign lvl_a  = lvl_r[AW-1:0];
  assign d_a    = d[AW-1:0];
  assign tail_a = tail[AW-1:0];
  assign k_cur  = choice_r[lvl_a];
  assign k_d    = choice_r[d_a];
  assign kp1    = CW'(k_d) + CW'(1);
  assign left   = CW'(n_eff) - CW'(d);
  assign more   = kp1 < left;

  // Last ordering: every level holds its highest choice.
  always_comb begin
    fin = 1'b1;
    for (int l = 0; l < DEPTH; l++) begin
      if (CW'(l) < CW'(n_eff) &&
          CW'(choice_r[l]) != CW'(n_eff) - CW'(l) - CW'(1)) begin
        fin = 1'b0;
      end
    end
  end

  always_comb begin
    pack = '0;
    for (int p = 0; p < DEPTH; p++) begin
      if (CW'(p) < CW'(n_eff)) begin
        pack[p*IDX_W +: IDX_W] = chosen_r[p];
      end
    end
  end

  // Single write port of the remaining-index store.
  always_comb begin
    we    = 1'b0;
    waddr = lvl_a;
    wdata = IDX_W'(lvl_r);
    if (cmd_i.sweep) begin
      we = 1'b1;
    end else if (cmd_i.take) begin
      we    = 1'b1;
      waddr = k_cur[AW-1:0];
      wdata = rd_b_r;
    end else if (cmd_i.unwind) begin
      we    = 1'b1;
      waddr = k_d[AW-1:0];
      wdata = chosen_r[d_a];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      rem_mem[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rd_a_r <= rem_mem[k_cur[AW-1:0]];
      rd_b_r <= rem_mem[tail_a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r     <= '0;
      cnt_r     <= '0;
      started_r <= 1'b0;
      ov_r      <= 1'b0;
      for (int l = 0; l < DEPTH; l++) begin
        choice_r[l] <= '0;
      end
    end else begin
      if (cfg_clr_i) begin
        started_r <= 1'b0;
      end
      if (cmd_i.init) begin
        lvl_r     <= '0;
        cnt_r     <= SEQ_W'(1);
        started_r <= 1'b1;
        for (int l = 0; l < DEPTH; l++) begin
          choice_r[l] <= '0;
        end
      end
      if (cmd_i.adv) begin
        lvl_r <= n_eff;
        cnt_r <= cnt_r + SEQ_W'(1);
      end
      if (cmd_i.sweep) begin
        lvl_r <= (lvl_r == n_m1) ? '0 : lvl_r + LW'(1);
      end
      if (cmd_i.take) begin
        lvl_r <= lvl_r + LW'(1);
      end
      if (cmd_i.unwind) begin
        lvl_r <= d;
        if (more) begin
          choice_r[d_a] <= IDX_W'(kp1);
          for (int l = 0; l < DEPTH; l++) begin
            if (CW'(l) > CW'(d)) begin
              choice_r[l] <= '0;
            end
          end
        end
      end
      // A new load wins over the transfer of the previous result.
      ov_r <= cmd_i.load || (ov_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.init) begin
      for (int l = 0; l < DEPTH; l++) begin
        chosen_r[l] <= '0;
      end
    end
    if (cmd_i.take) begin
      chosen_r[lvl_a] <= rd_a_r;
    end
    if (cmd_i.load) begin
      perm_r <= pack;
      seq_r  <= cnt_r;
      fin_r  <= fin;
    end
  end

  assign sts_o.started     = started_r;
  assign sts_o.final_now   = fin;
  assign sts_o.sweep_last  = (lvl_r == n_m1);
  assign sts_o.take_last   = (lvl_r == n_m1);
  assign sts_o.unwind_more = more;
  assign sts_o.out_free    = !ov_r || out_ch.ready;

  assign out_ch.valid           = ov_r;
  assign out_ch.permutation     = perm_r;
  assign out_ch.sequence_number = seq_r;
  assign out_ch.final_res       = fin_r;

  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.load |=> out_ch.valid && out_ch.sequence_number == $past(cnt_r))
    else $error("result sequence number does not match the running count");

  a_init_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.init |=> lvl_r == '0 && cnt_r == SEQ_W'(1))
    else $error("restart did not rewind level and count");

endmodule

// File: hw/rtl/pe_ctrl.sv
`timescale 1ns / 1ps

module pe_ctrl import pe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  pe_req_if.sink  in_ch,
  input  pe_sts_t sts_i,
  output pe_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_RD,
    S_TAKE,
    S_UNWIND,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;
  logic   in_ready_nxt;
  logic   accept;
  logic   need_start;

  assign accept     = in_ch.valid && in_ready_r;
  assign need_start = in_ch.restart || !sts_i.started || sts_i.final_now;

  always_comb begin
    cmd_o        = '0;
    state_nxt    = state_r;
    in_ready_nxt = in_ready_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          in_ready_nxt = 1'b0;
          if (need_start) begin
            cmd_o.init = 1'b1;
            state_nxt  = S_SWEEP;
          end else begin
            cmd_o.adv = 1'b1;
            state_nxt = S_UNWIND;
          end
        end
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd  = 1'b1;
        state_nxt = S_TAKE;
      end
      S_TAKE: begin
        cmd_o.take = 1'b1;
        state_nxt  = sts_i.take_last ? S_OUT : S_RD;
      end
      S_UNWIND: begin
        cmd_o.unwind = 1'b1;
        if (sts_i.unwind_more) begin
          state_nxt = S_RD;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load   = 1'b1;
          in_ready_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt    = S_IDLE;
        in_ready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ch.ready = in_ready_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request taken while previous one still in work");

  a_ready_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.load |=> in_ch.ready && state_r == S_IDLE)
    else $error("controller not idle after result load");

endmodule

// File: hw/rtl/permutation_enumerator_unit.sv
`timescale 1ns / 1ps

// Permutation enumerator: each request on in_ch returns the next ordering of
// the indices 0..n-1 on out_ch, packed 3 bits per position (position 0 in the
// low bits, positions at or beyond n read 0), with a sequence number that
// starts at 1 and a flag on the last ordering. restart = 1, a first request,
// or a request after the last ordering begins again at the first one.
// n comes from the item_count register on the APB-style cfg_ port (byte
// address 0, clamped to 1..MAX_ITEMS and 8); writing it forces a restart.
// Sequencing: one request at a time. A restart loads the remaining-index
// store one entry per level, then descends with a read and a take per level.
// A next request unwinds u levels and re-descends m levels (u, m <= n); the
// choice stack walk is one level per step through a single ported index
// store.
// Reset: item_count returns to 8 and the sequence restarts on the next
// request. The result sits in an output register: a new request is taken
// while it waits, but the next result holds in the datapath until the
// receiver takes the previous transfer.
module permutation_enumerator_unit import pe_pkg::*; #(
  parameter int MAX_ITEMS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pe_req_if.sink                in_ch,
  pe_res_if.source              out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // Storage depth: never more levels than packed positions.
  localparam int DEPTH = (MAX_ITEMS < PACK_SLOTS) ? MAX_ITEMS : PACK_SLOTS;

  logic [ITEM_COUNT_W-1:0] item_count_r;
  logic                    cfg_wr;
  logic                    sel_count;
  pe_cmd_t                 cmd;
  pe_sts_t                 sts;

  // Register access: decode the word address, write on the access phase.
  assign cfg_pready = 1'b1;
  assign sel_count  = (cfg_paddr[2] == REG_ITEM_COUNT);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && sel_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_count_r <= ITEM_COUNT_RESET;
    end else if (cfg_wr) begin
      item_count_r <= cfg_pwdata[ITEM_COUNT_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (sel_count) begin
      cfg_prdata = CFG_DATA_W'(item_count_r);
    end
  end

  // Sequencer: decides restart versus advance and steps the choice stack.
  pe_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  // Choice stack, remaining-index store, count and output register.
  pe_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_count_i (item_count_r),
    .cfg_clr_i    (cfg_wr),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ch       (out_ch)
  );

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> cfg_prdata[ITEM_COUNT_W-1:0] == $past(cfg_pwdata[ITEM_COUNT_W-1:0]) ||
               !sel_count)
    else $error("item_count readback differs from written value");

endmodule
